[rtl/core/fca_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and types for the FAT chain allocator.
// No dependencies; imported by the allocator top level.
package fca_pkg;

    localparam int NUM_BLOCKS = 1024;
    localparam int IDX_W      = $clog2(NUM_BLOCKS);     // table index / entry width
    localparam int CNT_W      = $clog2(NUM_BLOCKS) + 1; // counts up to NUM_BLOCKS
    localparam int BS_W       = 16;                     // block_size register
    localparam int BU_W       = 11;                     // blocks_in_use register
    localparam int CFG_W      = 16;                     // config write data
    localparam int LEN_W      = 32;                     // file size / byte offset
    localparam int ACC_W      = LEN_W + 1;
    localparam int SDATA_W    = 88;
    localparam int MDATA_W    = 16;

    typedef enum logic [2:0] {
        CMD_START  = 3'd0,
        CMD_APPEND = 3'd1,
        CMD_NEXT   = 3'd2,
        CMD_LOCATE = 3'd3,
        CMD_FREE   = 3'd4,
        CMD_WRITE  = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_BEYOND  = 2'd2
    } t_status;

    localparam logic CFG_BLOCK_SIZE    = 1'b0;
    localparam logic CFG_BLOCKS_IN_USE = 1'b1;

endpackage

[rtl/core/fca_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module fca_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/fat_chain_allocator.sv]
`timescale 1ns / 1ps
// Start chain searches the table entry by entry up to a free one or up to the search
// limit; append then links the new block behind the given one. Locate past the file end
// reports at once, else walks the chain, at most 1024 steps. One item in flight.
// Reset (synchronous, active low) clears control and config, then a clearing pass
// writes all 1024 table entries to zero with o_s_tready low.
module fat_chain_allocator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // config write port
    input  logic                        i_cfg_wr_en,
    input  logic                        i_cfg_index,
    input  logic [fca_pkg::CFG_W-1:0]   i_cfg_wdata,
    // command stream
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // block[9:0], entry_value[19:10], file_size[51:20], byte_offset[83:52], zero pad
    input  logic [fca_pkg::SDATA_W-1:0] i_s_tdata,
    // command[2:0]
    input  logic [2:0]                  i_s_tuser,
    // result stream
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // result_block[9:0], zero pad
    output logic [fca_pkg::MDATA_W-1:0] o_m_tdata,
    // status[1:0]
    output logic [1:0]                  o_m_tuser
);
    import fca_pkg::*;

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_SEARCH = 7'b0000100,
        S_LINK   = 7'b0001000,
        S_NEXT   = 7'b0010000,
        S_WALK   = 7'b0100000,
        S_FIN    = 7'b1000000
    } t_state;

    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_clr, n_clr;
    t_cmd                r_cmd, n_cmd;
    logic [IDX_W-1:0]    r_blk, n_blk;
    logic [LEN_W-1:0]    r_offs, n_offs;
    logic [CNT_W-1:0]    r_chk, n_chk;
    logic [IDX_W-1:0]    r_cur, n_cur;
    logic                r_cur_ram, n_cur_ram;
    logic [ACC_W-1:0]    r_acc, n_acc;
    logic [CNT_W-1:0]    r_steps, n_steps;
    logic [IDX_W-1:0]    r_res, n_res;
    t_status             r_st, n_st;
    logic [BS_W-1:0]     r_block_size;
    logic [BU_W-1:0]     r_blocks_in_use;
    logic                r_out_valid, n_out_valid;
    logic [IDX_W-1:0]    r_out_block, n_out_block;
    t_status             r_out_status, n_out_status;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [IDX_W-1:0]    ram_wdata;
    logic [IDX_W-1:0]    ram_raddr;
    logic [IDX_W-1:0]    ram_rdata;

    logic [IDX_W-1:0]    in_block;
    logic [IDX_W-1:0]    in_value;
    logic [LEN_W-1:0]    in_fsize;
    logic [LEN_W-1:0]    in_offs;
    t_cmd                in_cmd;
    logic                in_xfer;
    logic                out_load;

    logic [CNT_W-1:0]    limit;
    logic                search_end;
    logic                search_hit;
    logic [IDX_W-1:0]    walk_cur;
    logic [ACC_W-1:0]    walk_sum;
    logic                walk_go;

    assign in_block = i_s_tdata[IDX_W-1:0];
    assign in_value = i_s_tdata[2*IDX_W-1:IDX_W];
    assign in_fsize = i_s_tdata[2*IDX_W+LEN_W-1:2*IDX_W];
    assign in_offs  = i_s_tdata[2*IDX_W+2*LEN_W-1:2*IDX_W+LEN_W];
    assign in_cmd   = t_cmd'(i_s_tuser);

    assign o_s_tready = (r_state == S_IDLE);
    assign in_xfer    = i_s_tvalid && o_s_tready;
    assign out_load   = (r_state == S_FIN) && (!r_out_valid || i_m_tready);

    // free-block search: r_chk is the index whose entry sits on the RAM output
    assign limit      = (CNT_W'(r_blocks_in_use) > CNT_W'(NUM_BLOCKS)) ?
                        CNT_W'(NUM_BLOCKS) : CNT_W'(r_blocks_in_use);
    assign search_end = (r_chk >= limit);
    assign search_hit = !search_end && (ram_rdata == '0);

    // chain walk: another step while (steps+1)*block_size <= offset, capped
    assign walk_cur = r_cur_ram ? ram_rdata : r_cur;
    assign walk_sum = r_acc + ACC_W'(r_block_size);
    assign walk_go  = (r_steps < CNT_W'(NUM_BLOCKS)) && (walk_sum <= ACC_W'(r_offs));

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_cmd        = r_cmd;
        n_blk        = r_blk;
        n_offs       = r_offs;
        n_chk        = r_chk;
        n_cur        = r_cur;
        n_cur_ram    = r_cur_ram;
        n_acc        = r_acc;
        n_steps      = r_steps;
        n_res        = r_res;
        n_st         = r_st;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        ram_raddr    = '0;

        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                n_clr     = r_clr + 1'b1;
                if (r_clr == IDX_W'(NUM_BLOCKS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                ram_raddr = (in_cmd == CMD_NEXT) ? in_block : IDX_W'(1);
                if (in_xfer) begin
                    n_cmd = in_cmd;
                    n_blk = in_block;
                    n_res = '0;
                    n_st  = ST_OK;
                    unique case (in_cmd) inside
                        CMD_START, CMD_APPEND: begin
                            n_chk   = CNT_W'(1);
                            n_state = S_SEARCH;
                        end
                        CMD_NEXT: begin
                            n_state = S_NEXT;
                        end
                        CMD_LOCATE: begin
                            if (in_offs >= in_fsize) begin
                                n_st    = ST_BEYOND;
                                n_state = S_FIN;
                            end else begin
                                n_offs    = in_offs;
                                n_cur     = in_block;
                                n_cur_ram = 1'b0;
                                n_acc     = '0;
                                n_steps   = '0;
                                n_state   = S_WALK;
                            end
                        end
                        CMD_FREE, CMD_WRITE: begin
                            // entry 0 is reserved
                            ram_we    = (in_block != '0);
                            ram_waddr = in_block;
                            ram_wdata = (in_cmd == CMD_WRITE) ? in_value : '0;
                            n_state   = S_FIN;
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                ram_raddr = r_chk[IDX_W-1:0] + 1'b1;
                n_chk     = r_chk + 1'b1;
                if (search_end) begin
                    n_st    = ST_NO_FREE;
                    n_state = S_FIN;
                end else if (search_hit) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_chk[IDX_W-1:0];
                    ram_wdata = r_chk[IDX_W-1:0];
                    n_res     = r_chk[IDX_W-1:0];
                    n_state   = (r_cmd == CMD_APPEND) ? S_LINK : S_FIN;
                end
            end
            S_LINK: begin
                ram_we    = (r_blk != '0);
                ram_waddr = r_blk;
                ram_wdata = r_res;
                n_state   = S_FIN;
            end
            S_NEXT: begin
                n_res   = ram_rdata;
                n_state = S_FIN;
            end
            S_WALK: begin
                ram_raddr = walk_cur;
                if (walk_go) begin
                    n_cur_ram = 1'b1;
                    n_acc     = walk_sum;
                    n_steps   = r_steps + 1'b1;
                end else begin
                    n_res   = walk_cur;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_block  = r_out_block;
        n_out_status = r_out_status;
        if (out_load) begin
            n_out_valid  = 1'b1;
            n_out_block  = r_res;
            n_out_status = r_st;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_CLEAR;
            r_clr           <= '0;
            r_out_valid     <= 1'b0;
            r_block_size    <= BS_W'(512);
            r_blocks_in_use <= BU_W'(NUM_BLOCKS);
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_BLOCK_SIZE:    r_block_size    <= i_cfg_wdata[BS_W-1:0];
                    CFG_BLOCKS_IN_USE: r_blocks_in_use <= i_cfg_wdata[BU_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_blk        <= n_blk;
        r_offs       <= n_offs;
        r_chk        <= n_chk;
        r_cur        <= n_cur;
        r_cur_ram    <= n_cur_ram;
        r_acc        <= n_acc;
        r_steps      <= n_steps;
        r_res        <= n_res;
        r_st         <= n_st;
        r_out_block  <= n_out_block;
        r_out_status <= n_out_status;
    end

    fca_ram #(
        .WIDTH (IDX_W),
        .DEPTH (NUM_BLOCKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = MDATA_W'(r_out_block);
    assign o_m_tuser  = r_out_status;

`ifndef SYNTHESIS
    // the reserved entry is only touched by the clearing pass
    a_no_entry0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && (r_state != S_CLEAR)) |-> (ram_waddr != '0))
        else $error("write to reserved entry 0");

    // a failed command always reports block 0
    a_err_block_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser != ST_OK)) |-> (o_m_tdata == '0))
        else $error("error result with nonzero block");

    // walk never goes past the step cap
    a_walk_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_steps <= CNT_W'(NUM_BLOCKS)))
        else $error("chain walk past cap");

    // an allocated block is marked as a chain end in the same cycle
    a_alloc_marks_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SEARCH) && search_hit) |->
            (ram_we && (ram_wdata == ram_waddr) && (ram_waddr != '0)))
        else $error("allocation without end mark");
`endif

endmodule
